>>> rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the multi-stack shared-pool block: command
// and response beat layouts, action and status codes, the underflow value and default sizes.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int DEF_STACKS = 4;
  localparam int DEF_SLOTS  = 16;
  localparam int VALUE_W    = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                      action;
    logic [1:0]                stack_select;
    logic signed [VALUE_W-1:0] push_value;
  } msp_cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] popped_value;
    logic                      pool_full;
    logic                      selected_empty;
  } msp_rsp_t;

endpackage

>>> rtl/core/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Read data holds while re is low.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/msp_tops.sv
// ----------------------------------------------------------------------------
// msp_tops
// Top-of-stack pointer store: one entry per stack in a synchronous memory,
// with a valid bit per entry so that every stack reads as empty after reset.
// ----------------------------------------------------------------------------
module msp_tops #(
  parameter int STACKS = 4,
  parameter int SLOTS  = 16,
  parameter int ISW    = (STACKS > 1) ? $clog2(STACKS) : 1,
  parameter int PW     = $clog2(SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           we,
  input  logic [ISW-1:0] widx,
  input  logic [PW-1:0]  wdata,
  input  logic           re,
  input  logic [ISW-1:0] ridx,
  output logic [PW-1:0]  rdata
);

  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  logic [PW-1:0]     mem [STACKS];
  logic [STACKS-1:0] valid;
  logic [PW-1:0]     rd_mem;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    if (re) begin
      rd_mem <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[widx] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[ridx];
      end
    end
  end

  // an entry never written reads as an empty stack
  assign rdata = rd_valid ? rd_mem : NIL;

endmodule

>>> rtl/core/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// Several stacks sharing one pool of slots. Each slot has a value and a link;
// free slots form a free list. Push takes the free-list head and links it on
// top of the chosen stack; pop unlinks the top slot and returns it to the
// free list.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat      | handshake
//  --------+-----------+-----------+----------------------
//  cmd     | in        | msp_cmd_t | cmd_valid / cmd_ready
//  rsp     | out       | msp_rsp_t | rsp_valid / rsp_ready
//
// A push beat or a failed pop loads its response from the read state, once the
// output register is free; a successful pop first makes two dependent reads
// (top pointer, then the link and value of that slot) through the registered
// memory ports and loads its response from the pop state. One
// command is worked at a time; cmd_ready is high only while
// idle, including while a response waits in the output register.
// Reset clears the stack valid bits, the free-list head and the fill mark;
// no clearing pass is needed, so commands are taken the cycle after reset.
// A stalled response holds the sequencer in its last step until it drains.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool #(
  parameter int STACKS = msp_pkg::DEF_STACKS,
  parameter int SLOTS  = msp_pkg::DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  msp_pkg::msp_cmd_t cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output msp_pkg::msp_rsp_t rsp
);
  import msp_pkg::*;

  localparam int AW  = $clog2(SLOTS);
  localparam int PW  = $clog2(SLOTS + 1);
  localparam int ISW = (STACKS > 1) ? $clog2(STACKS) : 1;
  // null pointer: one past the last slot
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]        state, state_next;
  msp_cmd_t          cmd_q;
  logic              sel_ok;
  logic [PW-1:0]     free_head, free_head_next;
  // slots at or above the fill mark were never handed out; their link is
  // implicitly the next slot, as in the chained free list after reset
  logic [PW-1:0]     water, water_next;
  logic [PW-1:0]     link_addr;
  logic [PW-1:0]     top;

  logic              accept;
  logic              can_emit;
  logic              emit;
  msp_rsp_t          rsp_next;

  logic              tops_we, tops_re;
  logic [ISW-1:0]    tops_ridx, sel_idx;
  logic [PW-1:0]     tops_wdata, tops_rd;

  logic              link_we, link_re;
  logic [PW-1:0]     link_waddr, link_raddr, link_wdata, link_rd;
  logic [PW-1:0]     link_raw, link_next;

  logic              val_we, val_re;
  logic [AW-1:0]     val_addr_w, val_addr_r;
  logic [VALUE_W-1:0] val_rd;

  logic              top_nil, fh_nil;

  msp_tops #(
    .STACKS (STACKS),
    .SLOTS  (SLOTS),
    .ISW    (ISW),
    .PW     (PW)
  ) u_tops (
    .clk   (clk),
    .rst   (rst),
    .we    (tops_we),
    .widx  (sel_idx),
    .wdata (tops_wdata),
    .re    (tops_re),
    .ridx  (tops_ridx),
    .rdata (tops_rd)
  );

  msp_ram #(
    .W (PW),
    .D (SLOTS)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr[AW-1:0]),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr[AW-1:0]),
    .rdata (link_rd)
  );

  msp_ram #(
    .W (VALUE_W),
    .D (SLOTS)
  ) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_addr_w),
    .wdata (cmd_q.push_value),
    .re    (val_re),
    .raddr (val_addr_r),
    .rdata (val_rd)
  );

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign can_emit  = !rsp_valid || rsp_ready;
  assign tops_ridx = ISW'(cmd.stack_select);
  assign sel_idx   = ISW'(cmd_q.stack_select);

  assign top_nil = (tops_rd >= NIL);
  assign fh_nil  = (free_head >= NIL);

  // link of the slot last read: fresh slots chain to their neighbour
  assign link_raw  = (link_addr >= water) ? link_addr + PW'(1) : link_rd;
  assign link_next = (link_raw >= NIL) ? NIL : link_raw;

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    water_next     = water;
    emit           = 1'b0;
    rsp_next       = '0;
    tops_we        = 1'b0;
    tops_re        = 1'b0;
    tops_wdata     = tops_rd;
    link_we        = 1'b0;
    link_re        = 1'b0;
    link_waddr     = free_head;
    link_wdata     = tops_rd;
    link_raddr     = free_head;
    val_we         = 1'b0;
    val_re         = 1'b0;
    val_addr_w     = free_head[AW-1:0];
    val_addr_r     = tops_rd[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          // fetch the addressed top and the link behind the free-list head
          tops_re    = 1'b1;
          link_re    = 1'b1;
          link_raddr = free_head;
          state_next = S_READ;
        end
      end

      S_READ: begin
        if (cmd_q.action == ACT_PUSH) begin
          if (can_emit) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (!sel_ok || fh_nil) begin
              rsp_next.status         = ST_OVERFLOW;
              rsp_next.pool_full      = fh_nil;
              rsp_next.selected_empty = !sel_ok || top_nil;
            end else begin
              // link the free-list head on top of the stack and fill it
              link_we        = 1'b1;
              link_waddr     = free_head;
              link_wdata     = tops_rd;
              val_we         = 1'b1;
              val_addr_w     = free_head[AW-1:0];
              tops_we        = 1'b1;
              tops_wdata     = free_head;
              free_head_next = link_next;
              if (free_head >= water) begin
                water_next = free_head + PW'(1);
              end
              rsp_next.status         = ST_DONE;
              rsp_next.pool_full      = (link_next == NIL);
              rsp_next.selected_empty = 1'b0;
            end
          end
        end else begin
          if (!sel_ok || top_nil) begin
            if (can_emit) begin
              emit                    = 1'b1;
              state_next              = S_IDLE;
              rsp_next.status         = ST_UNDERFLOW;
              rsp_next.popped_value   = UNDERFLOW_VALUE;
              rsp_next.pool_full      = fh_nil;
              rsp_next.selected_empty = 1'b1;
            end
          end else begin
            // second dependent read: link and value of the top slot
            link_re    = 1'b1;
            link_raddr = tops_rd;
            val_re     = 1'b1;
            val_addr_r = tops_rd[AW-1:0];
            state_next = S_POP;
          end
        end
      end

      S_POP: begin
        if (can_emit) begin
          emit           = 1'b1;
          state_next     = S_IDLE;
          // unlink the top slot and push it onto the free list
          tops_we        = 1'b1;
          tops_wdata     = link_next;
          link_we        = 1'b1;
          link_waddr     = top;
          link_wdata     = free_head;
          free_head_next = top;
          rsp_next.status         = ST_DONE;
          rsp_next.popped_value   = $signed(val_rd);
          rsp_next.pool_full      = 1'b0;
          rsp_next.selected_empty = (link_next == NIL);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      water     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      water     <= water_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers: hold the command, the stack-select check, the last link address, the top and the response
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      sel_ok <= (int'(cmd.stack_select) < STACKS);
    end
    if (link_re) begin
      link_addr <= link_raddr;
    end
    if (state == S_READ) begin
      top <= tops_rd;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks for the multi-stack shared-pool block, bound to the top.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input msp_pkg::msp_cmd_t cmd,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input msp_pkg::msp_rsp_t rsp
);
  import msp_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat dropped or changed while stalled");

  a_no_rsp_after_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid straight after reset");

  a_underflow_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_UNDERFLOW |->
      rsp.popped_value == UNDERFLOW_VALUE && rsp.selected_empty)
    else $error("underflow beat with wrong value or non-empty stack");

  a_overflow_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OVERFLOW |->
      rsp.popped_value == 0 && (rsp.pool_full || rsp.selected_empty))
    else $error("overflow beat without a full pool or a bad stack");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_DONE || rsp.status == ST_OVERFLOW ||
      rsp.status == ST_UNDERFLOW)
    else $error("undefined status code");

endmodule

bind multi_stack_shared_pool msp_checker u_msp_checker (.*);

>>> verif/multi_stack_shared_pool_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_test
// Self-checking bench for the shared-pool stack block. A directed table walks
// empty pops, a fill to full, overflow and drains. Random beats follow, in
// fill, drain, mixed and single-stack segments, with idle bursts on both
// channels. Each response beat is checked field by field against a local
// model of the pool, free list and stack tops, or a response given in the table.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_test;
  import msp_pkg::*;

  localparam int N_STACKS     = DEF_STACKS;
  localparam int N_SLOTS      = DEF_SLOTS;
  localparam int PTR_W        = $clog2(N_SLOTS + 1);
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_ITEMS  = 150;
  localparam int DIR_ROWS     = 25;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 60;

  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(N_SLOTS);

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_FOCUS} mix_mode_t;

  typedef struct {
    msp_cmd_t cmd;
    bit       typed;
    msp_rsp_t rsp;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  msp_cmd_t cmd       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  msp_rsp_t rsp;

  // Model of the pool: values, links, stack tops and the free-list head
  logic signed [VALUE_W-1:0] value_mem [N_SLOTS];
  logic [PTR_W-1:0]          link_mem  [N_SLOTS];
  logic [PTR_W-1:0]          top_of    [N_STACKS];
  logic [PTR_W-1:0]          free_ptr;

  msp_rsp_t pending_rsp [$];
  msp_rsp_t rsp_want;
  dir_row_t dir_table [DIR_ROWS];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       quiet       = 1'b0;

  multi_stack_shared_pool #(
    .STACKS(N_STACKS),
    .SLOTS (N_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop: a hung handshake ends the run here
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("multi_stack_shared_pool verification failed");
    $finish;
  end

  task automatic report(string what);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // Chain every slot into the free list and empty every stack
  task automatic pool_clear();
    for (int i = 0; i < N_SLOTS; i++) begin
      value_mem[i] = '0;
      link_mem[i]  = (i + 1 < N_SLOTS) ? PTR_W'(i + 1) : NO_SLOT;
    end
    for (int i = 0; i < N_STACKS; i++) begin
      top_of[i] = NO_SLOT;
    end
    free_ptr = '0;
  endtask

  // Apply one command beat to the model and return the response it gives
  function automatic msp_rsp_t pool_step(msp_cmd_t c);
    msp_rsp_t         r;
    logic [PTR_W-1:0] s;
    bit               sel_ok;
    r      = '0;
    sel_ok = c.stack_select < N_STACKS;
    if (c.action == ACT_PUSH) begin
      if (!sel_ok || free_ptr >= N_SLOTS) begin
        r.status = ST_OVERFLOW;
      end else begin
        s                      = free_ptr;
        free_ptr               = (link_mem[s] < N_SLOTS) ? link_mem[s] : NO_SLOT;
        link_mem[s]            = top_of[c.stack_select];
        top_of[c.stack_select] = s;
        value_mem[s]           = c.push_value;
        r.status               = ST_DONE;
      end
    end else begin
      if (!sel_ok || top_of[c.stack_select] >= N_SLOTS) begin
        r.status       = ST_UNDERFLOW;
        r.popped_value = UNDERFLOW_VALUE;
      end else begin
        s                      = top_of[c.stack_select];
        top_of[c.stack_select] = (link_mem[s] < N_SLOTS) ? link_mem[s] : NO_SLOT;
        link_mem[s]            = free_ptr;
        free_ptr               = s;
        r.popped_value         = value_mem[s];
        r.status               = ST_DONE;
      end
    end
    r.pool_full      = free_ptr >= N_SLOTS;
    r.selected_empty = !sel_ok || top_of[c.stack_select] >= N_SLOTS;
    return r;
  endfunction

  function automatic dir_row_t row(logic act, logic [1:0] sel, logic [VALUE_W-1:0] val);
    dir_row_t d;
    d.cmd   = '{action: act, stack_select: sel, push_value: val};
    d.typed = 1'b0;
    d.rsp   = '0;
    return d;
  endfunction

  function automatic dir_row_t row_rsp(logic act, logic [1:0] sel, logic [VALUE_W-1:0] val,
                                       logic [1:0] st, logic [VALUE_W-1:0] pv,
                                       logic full, logic empty);
    dir_row_t d;
    d       = row(act, sel, val);
    d.typed = 1'b1;
    d.rsp   = '{status: st, popped_value: pv, pool_full: full, selected_empty: empty};
    return d;
  endfunction

  // Offer one command beat, hold it until taken, then queue its expected
  // response. A random idle burst may come first unless the run is quiet.
  task automatic send_cmd(msp_cmd_t c, bit typed, msp_rsp_t typed_rsp);
    msp_rsp_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predicted = pool_step(c);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // Response side: stall in random bursts between runs of ready,
  // with no stalls once the run turns quiet
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Check every response beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report($sformatf("response beat with nothing pending, status %0d", rsp.status));
      end else begin
        rsp_want = pending_rsp.pop_front();
        if (rsp.status !== rsp_want.status) begin
          report($sformatf("status got %0d want %0d", rsp.status, rsp_want.status));
        end
        if (rsp.popped_value !== rsp_want.popped_value) begin
          report($sformatf("popped_value got %h want %h",
                           rsp.popped_value, rsp_want.popped_value));
        end
        if (rsp.pool_full !== rsp_want.pool_full) begin
          report($sformatf("pool_full got %b want %b", rsp.pool_full, rsp_want.pool_full));
        end
        if (rsp.selected_empty !== rsp_want.selected_empty) begin
          report($sformatf("selected_empty got %b want %b",
                           rsp.selected_empty, rsp_want.selected_empty));
        end
      end
    end
  end

  initial begin
    msp_cmd_t  c;
    mix_mode_t mode;
    int        push_pct;
    logic [1:0] focus;

    pool_clear();
    mode  = MODE_MIXED;
    focus = '0;

    // Pops on empty stacks straight after reset give underflow; then two pushes onto stack 0
    dir_table[0]  = row_rsp(ACT_POP,  2'd0, 32'h0000_0000,
                            ST_UNDERFLOW, UNDERFLOW_VALUE, 1'b0, 1'b1);
    dir_table[1]  = row_rsp(ACT_POP,  2'd3, 32'hFFFF_FFFF,
                            ST_UNDERFLOW, UNDERFLOW_VALUE, 1'b0, 1'b1);
    dir_table[2]  = row_rsp(ACT_PUSH, 2'd0, 32'h7FFF_FFFF, ST_DONE, '0, 1'b0, 1'b0);
    dir_table[3]  = row(ACT_PUSH, 2'd0, 32'h8000_0000);
    // Fill the rest of the pool across all four stacks
    dir_table[4]  = row(ACT_PUSH, 2'd0, 32'h0000_0000);
    dir_table[5]  = row(ACT_PUSH, 2'd1, 32'hFFFF_FFFF);
    dir_table[6]  = row(ACT_PUSH, 2'd2, 32'h0000_0001);
    dir_table[7]  = row(ACT_PUSH, 2'd3, 32'h8000_0001);
    dir_table[8]  = row(ACT_PUSH, 2'd0, 32'h5555_5555);
    dir_table[9]  = row(ACT_PUSH, 2'd1, 32'hAAAA_AAAA);
    dir_table[10] = row(ACT_PUSH, 2'd2, 32'h7FFF_FFFE);
    dir_table[11] = row(ACT_PUSH, 2'd3, 32'h1234_5678);
    dir_table[12] = row(ACT_PUSH, 2'd0, 32'hFEDC_BA98);
    dir_table[13] = row(ACT_PUSH, 2'd1, 32'h00FF_00FF);
    dir_table[14] = row(ACT_PUSH, 2'd2, 32'hFF00_FF00);
    dir_table[15] = row(ACT_PUSH, 2'd3, 32'h0F0F_0F0F);
    dir_table[16] = row(ACT_PUSH, 2'd0, 32'hF0F0_F0F0);
    dir_table[17] = row(ACT_PUSH, 2'd1, 32'h0000_0003);
    // Push on a full pool: overflow, nothing changes
    dir_table[18] = row_rsp(ACT_PUSH, 2'd1, 32'hDEAD_BEEF, ST_OVERFLOW, '0, 1'b1, 1'b0);
    // Free a slot, reuse it, then pop once from each stack
    dir_table[19] = row(ACT_POP,  2'd0, 32'h0000_0000);
    dir_table[20] = row(ACT_PUSH, 2'd0, 32'h8000_0000);
    dir_table[21] = row(ACT_POP,  2'd0, 32'hFFFF_FFFF);
    dir_table[22] = row(ACT_POP,  2'd2, 32'h0000_0000);
    dir_table[23] = row(ACT_POP,  2'd3, 32'h0000_0000);
    dir_table[24] = row(ACT_POP,  2'd1, 32'h0000_0000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].rsp);
    end

    // Random part in segments: fill segments favour pushes, drain segments favour
    // pops, focus segments pile onto one stack
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode  = mix_mode_t'($urandom_range(0, 3));
        focus = 2'($urandom_range(0, N_STACKS - 1));
      end
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      case (mode)
        MODE_FILL:  push_pct = 80;
        MODE_DRAIN: push_pct = 20;
        default:    push_pct = 50;
      endcase
      c.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
      if (mode == MODE_FOCUS && $urandom_range(0, 3) != 0) begin
        c.stack_select = focus;
      end else begin
        c.stack_select = 2'($urandom_range(0, N_STACKS - 1));
      end
      case ($urandom_range(0, 9))
        0:       c.push_value = 32'h7FFF_FFFF;
        1:       c.push_value = 32'h8000_0000;
        2:       c.push_value = 32'h0000_0000;
        3:       c.push_value = 32'hFFFF_FFFF;
        default: c.push_value = $urandom;
      endcase
      send_cmd(c, 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    // Drain: wait for every pending response, then for any stray beats
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("multi_stack_shared_pool verification clean");
    end else begin
      $display("multi_stack_shared_pool verification failed");
    end
    $finish;
  end

endmodule
